### hw/rtl/mtks_pkg.sv
// mtks_pkg: shared types, codes and constants of the multi-tap key sequencer
// no dependencies; imported by every module of the block

package mtks_pkg;

    localparam int TAP_KEYS = 16;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    // input operation codes
    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // result event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_CYCLE   = 2'd1;
    localparam logic [1:0] EV_FINISH  = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_TIMEOUT    = 2'd0;
    localparam logic [1:0] REG_FIRST_CODE = 2'd1;
    localparam logic [1:0] REG_LAST_CODE  = 2'd2;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [15:0] first_code;
        logic [15:0] last_code;
    } t_cfg;

    typedef struct packed {
        logic [1:0] event_res;
        logic [3:0] tap_index;
        logic [7:0] tap_count;
    } t_result;

    // all results caused by one input item
    typedef struct packed {
        logic       handled;
        logic [1:0] nres;
        t_result [2:0] res;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

### hw/rtl/multi_tap_key_sequencer.sv
// multi_tap_key_sequencer: top level with apb configuration registers
// depends on mtks_pkg, mtks_front, mtks_queue, mtks_back
//
// Counts repeated taps of a multi-tap key and reports cycle, finish and release
// events. An input transaction (tuser = operation, tdata = keycode) is taken in
// any cycle in which the four-entry result queue has room, so items enter back
// to back. Each item yields one to three results, which leave one per cycle
// while the receiver is ready, from a registered output, the final one with
// tlast set; this output rate sets the sustained throughput. The first result
// is registered at the output after its item has been written into the queue.
// Configuration (timeout, first and last multi-tap keycode) is to be written
// over the apb port only while idle; the block does not enforce this.

module multi_tap_key_sequencer
    import mtks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] keycode
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [3:0] tap_index, [11:4] tap_count, [15:12] zero
    output logic [2:0]  o_m_tuser,   // [1:0] event_res, [2] handled
    output logic        o_m_tlast
);

    t_cfg    r_cfg;
    logic    push, pop;
    t_entry  entry, head;
    t_qstat  qstat;
    t_result res;
    logic    handled;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= 16'd200;
            r_cfg.first_code    <= 16'd0;
            r_cfg.last_code     <= 16'd15;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_TIMEOUT:    r_cfg.timeout_ticks <= pwdata[15:0];
                REG_FIRST_CODE: r_cfg.first_code    <= pwdata[15:0];
                REG_LAST_CODE:  r_cfg.last_code     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TIMEOUT:    prdata = {16'd0, r_cfg.timeout_ticks};
            REG_FIRST_CODE: prdata = {16'd0, r_cfg.first_code};
            REG_LAST_CODE:  prdata = {16'd0, r_cfg.last_code};
            default:        prdata = 32'd0;
        endcase
    end

    mtks_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_operation (i_s_tuser),
        .i_keycode   (i_s_tdata),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_entry     (entry)
    );

    mtks_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    mtks_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_qstat   (qstat),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_res     (res),
        .o_handled (handled),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {4'd0, res.tap_count, res.tap_index};
    assign o_m_tuser = {handled, res.event_res};

endmodule

### hw/rtl/mtks_front.sv
// mtks_front: accepts key and tick items, runs the sequencer state and builds
// the list of results for each item; depends on mtks_pkg

module mtks_front
    import mtks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_keycode,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_entry      o_entry
);

    logic [15:0] r_held, n_held;
    logic [7:0]  r_taps, n_taps;
    logic [15:0] r_elapsed, n_elapsed;
    logic [3:0]  r_cur, n_cur;
    logic        r_wi, n_wi;

    logic [15:0] off;
    logic        in_range;
    logic [3:0]  idx;
    logic        do_fin;
    logic [3:0]  fidx;
    t_entry      ent;

    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && o_ready;
    assign o_entry = ent;

    always_comb begin
        n_held    = r_held;
        n_taps    = r_taps;
        n_elapsed = r_elapsed;
        n_cur     = r_cur;
        n_wi      = r_wi;
        ent       = '0;
        do_fin    = 1'b0;
        fidx      = r_cur;

        off      = i_keycode - i_cfg.first_code;
        in_range = (i_keycode >= i_cfg.first_code) && (i_keycode <= i_cfg.last_code)
                   && (off < 16'(TAP_KEYS));
        idx      = off[3:0];

        // interruption or timeout may finish the running sequence first
        case (i_operation)
            OP_PRESS: begin
                if (n_taps != 8'd0 && (!in_range || idx != n_cur)) begin
                    n_wi   = 1'b1;
                    do_fin = 1'b1;
                end
            end
            OP_TICK: begin
                if (n_taps != 8'd0 && n_elapsed != 16'hFFFF)
                    n_elapsed = n_elapsed + 16'd1;
                if (n_elapsed >= i_cfg.timeout_ticks)
                    do_fin = 1'b1;
            end
            default: ;
        endcase

        if (do_fin) begin
            ent.res[0] = '{EV_FINISH, fidx, n_taps};
            ent.nres   = 2'd1;
            if (!n_held[fidx] || n_elapsed >= i_cfg.timeout_ticks) begin
                ent.res[1]   = '{EV_RELEASE, fidx, n_taps};
                ent.nres     = 2'd2;
                n_held[fidx] = 1'b0;
                n_cur        = 4'd0;
                n_taps       = 8'd0;
                n_elapsed    = 16'd0;
                n_wi         = 1'b0;
            end
        end

        case (i_operation)
            OP_PRESS: begin
                if (in_range) begin
                    ent.handled       = 1'b1;
                    n_cur             = idx;
                    n_elapsed         = 16'd0;
                    n_taps            = n_taps + 8'd1;
                    n_held[idx]       = 1'b1;
                    ent.res[ent.nres] = '{EV_CYCLE, idx, n_taps};
                    ent.nres          = ent.nres + 2'd1;
                end
            end
            OP_RELEASE: begin
                if (in_range) begin
                    ent.handled = 1'b1;
                    if (idx == n_cur) begin
                        n_held[idx] = 1'b0;
                        if (n_elapsed >= i_cfg.timeout_ticks || n_wi) begin
                            ent.res[0] = '{EV_RELEASE, idx, n_taps};
                            ent.nres   = 2'd1;
                            n_cur      = 4'd0;
                            n_taps     = 8'd0;
                            n_elapsed  = 16'd0;
                            n_wi       = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (ent.nres == 2'd0) begin
            ent.res[0] = '{EV_NONE, 4'd0, 8'd0};
            ent.nres   = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_taps    <= '0;
            r_elapsed <= '0;
            r_cur     <= '0;
            r_wi      <= 1'b0;
        end else if (o_push) begin
            r_held    <= n_held;
            r_taps    <= n_taps;
            r_elapsed <= n_elapsed;
            r_cur     <= n_cur;
            r_wi      <= n_wi;
        end
    end

endmodule

### hw/rtl/mtks_queue.sv
// mtks_queue: small fifo of per-item result lists between front and back
// depends on mtks_pkg

module mtks_queue
    import mtks_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output t_qstat o_qstat
);

    t_entry            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr, r_rptr;
    logic [Q_AW:0]     r_count;

    assign o_head        = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wptr <= r_wptr + 1'b1;
            if (i_pop)
                r_rptr <= r_rptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/mtks_back.sv
// mtks_back: walks each queued result list and drives one result per transaction
// through a registered output; depends on mtks_pkg

module mtks_back
    import mtks_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_entry  i_head,
    input  t_qstat  i_qstat,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res,
    output logic    o_handled,
    output logic    o_last
);

    logic       r_valid;
    t_result    r_res;
    logic       r_handled;
    logic       r_last;
    logic [1:0] r_sel;

    logic load;
    logic at_end;

    assign load    = (!r_valid || i_ready) && !i_qstat.empty;
    assign at_end  = (r_sel == i_head.nres - 2'd1);
    assign o_pop   = load && at_end;

    assign o_valid   = r_valid;
    assign o_res     = r_res;
    assign o_handled = r_handled;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sel   <= at_end ? 2'd0 : r_sel + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res     <= i_head.res[r_sel];
            r_handled <= i_head.handled;
            r_last    <= at_end;
        end
    end

endmodule

### tb/sv/tb_multi_tap_key_sequencer.sv
// tb_multi_tap_key_sequencer: self-checking testbench for the multi-tap key sequencer
// depends on mtks_pkg and multi_tap_key_sequencer; directed table, then random phases
// checked against a cycle-free predictor of taps, timer and held keys
`timescale 1ns / 1ps

module tb_multi_tap_key_sequencer
    import mtks_pkg::*;
();

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 60;

    typedef struct packed {
        logic [1:0] event_res;
        logic [3:0] tap_index;
        logic [7:0] tap_count;
        logic       handled;
        logic       last;
    } t_key_res;

    typedef enum logic [1:0] { ROW_ITEM, ROW_TYPED, ROW_CFG } t_row_kind;

    // cfg rows use rsel and kc as register index and value
    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] rsel;
        logic [1:0] op;
        logic [15:0] kc;
        t_key_res   want;
    } t_dir_row;

    typedef struct {
        logic [15:0] ticks;
        logic [15:0] lo_code;
        logic [15:0] hi_code;
        int          send_pct;
        int          recv_pct;
    } t_run_mode;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [3:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // [15:0] keycode
    logic [1:0]  i_s_tuser  = '0;   // [1:0] operation
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [3:0] tap_index, [11:4] tap_count, [15:12] zero
    logic [2:0]  o_m_tuser;         // [1:0] event_res, [2] handled
    logic        o_m_tlast;

    multi_tap_key_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // predictor copy of the block state and registers
    logic [15:0] held_mask;
    logic [7:0]  tap_cnt;
    logic [15:0] tick_age;
    logic [3:0]  cur_key;
    logic        broken_off;
    logic [15:0] cfg_timeout;
    logic [15:0] cfg_first;
    logic [15:0] cfg_last;

    t_key_res step_q[$];
    t_key_res tap_events_q[$];

    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void note_event(logic [1:0] ev, logic [3:0] idx, logic [7:0] cnt);
        step_q.push_back('{ev, idx, cnt, 1'b0, 1'b0});
    endfunction

    function automatic void clear_taps();
        cur_key    = '0;
        tap_cnt    = '0;
        tick_age   = '0;
        broken_off = 1'b0;
    endfunction

    // finish the running sequence; released too when the key is up or time is out
    function automatic void finish_taps();
        logic [3:0] k;
        k = cur_key;
        note_event(EV_FINISH, k, tap_cnt);
        if (!held_mask[k] || tick_age >= cfg_timeout) begin
            note_event(EV_RELEASE, k, tap_cnt);
            clear_taps();
            held_mask[k] = 1'b0;
        end
    endfunction

    function automatic logic is_tap_key(input logic [15:0] kc, output logic [3:0] idx);
        logic [15:0] off;
        idx = '0;
        if (kc < cfg_first || kc > cfg_last) return 1'b0;
        off = kc - cfg_first;
        if (off >= TAP_KEYS) return 1'b0;
        idx = off[3:0];
        return 1'b1;
    endfunction

    function automatic void predict_taps(logic [1:0] op, logic [15:0] kc);
        logic [3:0] idx;
        logic       hit;
        logic       hnd;
        hnd = 1'b0;
        step_q.delete();
        hit = is_tap_key(kc, idx);
        case (op)
            OP_PRESS: begin
                if (!hit) begin
                    if (tap_cnt != 0) begin
                        broken_off = 1'b1;
                        finish_taps();
                    end
                end else begin
                    hnd = 1'b1;
                    if (tap_cnt != 0 && idx != cur_key) begin
                        broken_off = 1'b1;
                        finish_taps();
                    end
                    cur_key = idx;
                    tick_age = '0;
                    tap_cnt = tap_cnt + 8'd1;
                    held_mask[idx] = 1'b1;
                    note_event(EV_CYCLE, idx, tap_cnt);
                end
            end
            OP_RELEASE: begin
                if (hit) begin
                    hnd = 1'b1;
                    if (idx == cur_key) begin
                        held_mask[idx] = 1'b0;
                        if (tick_age >= cfg_timeout || broken_off) begin
                            note_event(EV_RELEASE, idx, tap_cnt);
                            clear_taps();
                        end
                    end
                end
            end
            OP_TICK: begin
                // timer runs only with taps pending and stops at full scale
                if (tap_cnt != 0 && tick_age != 16'hFFFF) tick_age = tick_age + 16'd1;
                if (tick_age >= cfg_timeout) finish_taps();
            end
            default: ;
        endcase
        if (step_q.size() == 0) note_event(EV_NONE, '0, '0);
        foreach (step_q[i]) step_q[i].handled = hnd;
        step_q[step_q.size() - 1].last = 1'b1;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [15:0] kc,
                             input logic typed, input t_key_res want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= kc;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_taps(op, kc);
        if (typed) begin
            step_q.delete();
            step_q.push_back(want);
        end
        foreach (step_q[i]) tap_events_q.push_back(step_q[i]);
        items_sent++;
    endtask

    // sender stops and waits for every outstanding result
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (tap_events_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] rsel, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {rsel, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (rsel)
            REG_TIMEOUT:    cfg_timeout = val;
            REG_FIRST_CODE: cfg_first = val;
            REG_LAST_CODE:  cfg_last = val;
            default: ;
        endcase
        cfg_writes++;
        @(posedge i_clk);
    endtask

    // receiver: random stalls plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                hold_left = HOLD_OFF_CYCLES;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_key_res got;
        t_key_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tuser[1:0], o_m_tdata[3:0], o_m_tdata[11:4], o_m_tuser[2], o_m_tlast};
            if (tap_events_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result ev=%0d idx=%0d cnt=%0d handled=%0d last=%0d",
                         $time, got.event_res, got.tap_index, got.tap_count, got.handled,
                         got.last);
            end else begin
                want = tap_events_q.pop_front();
                results_seen++;
                if (got != want) begin
                    mismatches++;
                    $display("%0t: expected ev=%0d idx=%0d cnt=%0d handled=%0d last=%0d",
                             $time, want.event_res, want.tap_index, want.tap_count,
                             want.handled, want.last);
                    $display("%0t:      got ev=%0d idx=%0d cnt=%0d handled=%0d last=%0d",
                             $time, got.event_res, got.tap_index, got.tap_count,
                             got.handled, got.last);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding", $time,
                     tap_events_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        t_dir_row    dir_tab [29];
        t_run_mode   modes [7];
        logic [1:0]  op;
        logic [15:0] kc;
        logic [15:0] focus;
        int          r;

        cfg_timeout = 16'd200;
        cfg_first   = 16'd0;
        cfg_last    = 16'd15;
        held_mask   = '0;
        clear_taps();

        dir_tab = '{
            '{ROW_TYPED, REG_TIMEOUT, OP_PRESS,   16'd3,   '{EV_CYCLE, 4'd3, 8'd1, 1'b1, 1'b1}},
            '{ROW_TYPED, REG_TIMEOUT, OP_RELEASE, 16'd3,   '{EV_NONE, 4'd0, 8'd0, 1'b1, 1'b1}},
            '{ROW_ITEM,  REG_TIMEOUT, OP_PRESS,   16'd3,   '0},
            // other key interrupts a held key: finish only
            '{ROW_ITEM,  REG_TIMEOUT, OP_PRESS,   16'hFFFF, '0},
            '{ROW_TYPED, REG_TIMEOUT, OP_TICK,    16'd0,   '{EV_NONE, 4'd0, 8'd0, 1'b0, 1'b1}},
            '{ROW_TYPED, REG_TIMEOUT, OP_UNUSED,  16'hFFFF, '{EV_NONE, 4'd0, 8'd0, 1'b0, 1'b1}},
            '{ROW_ITEM,  REG_TIMEOUT, OP_PRESS,   16'd15,  '0},
            // different multi-tap key while the first is held
            '{ROW_ITEM,  REG_TIMEOUT, OP_PRESS,   16'd0,   '0},
            '{ROW_ITEM,  REG_TIMEOUT, OP_RELEASE, 16'd15,  '0},
            '{ROW_ITEM,  REG_TIMEOUT, OP_RELEASE, 16'd0,   '0},
            '{ROW_TYPED, REG_TIMEOUT, OP_PRESS,   16'd16,  '{EV_NONE, 4'd0, 8'd0, 1'b0, 1'b1}},
            '{ROW_TYPED, REG_TIMEOUT, OP_RELEASE, 16'd20,  '{EV_NONE, 4'd0, 8'd0, 1'b0, 1'b1}},
            '{ROW_CFG,   REG_TIMEOUT, OP_PRESS,   16'd0,   '0},
            // zero timeout: every tick finishes and releases
            '{ROW_ITEM,  REG_TIMEOUT, OP_TICK,    16'd0,   '0},
            '{ROW_ITEM,  REG_TIMEOUT, OP_PRESS,   16'd5,   '0},
            '{ROW_ITEM,  REG_TIMEOUT, OP_RELEASE, 16'd5,   '0},
            '{ROW_ITEM,  REG_TIMEOUT, OP_PRESS,   16'd6,   '0},
            '{ROW_ITEM,  REG_TIMEOUT, OP_TICK,    16'd0,   '0},
            '{ROW_CFG,   REG_TIMEOUT, OP_PRESS,   16'hFFFF, '0},
            '{ROW_CFG,   REG_FIRST_CODE, OP_PRESS, 16'hFFF0, '0},
            '{ROW_CFG,   REG_LAST_CODE,  OP_PRESS, 16'hFFFF, '0},
            '{ROW_TYPED, REG_TIMEOUT, OP_PRESS,   16'hFFFF, '{EV_CYCLE, 4'd15, 8'd1, 1'b1, 1'b1}},
            '{ROW_ITEM,  REG_TIMEOUT, OP_PRESS,   16'hFFF0, '0},
            '{ROW_ITEM,  REG_TIMEOUT, OP_PRESS,   16'd0,   '0},
            '{ROW_ITEM,  REG_TIMEOUT, OP_RELEASE, 16'hFFF0, '0},
            // first above last: empty range
            '{ROW_CFG,   REG_FIRST_CODE, OP_PRESS, 16'd100, '0},
            '{ROW_CFG,   REG_LAST_CODE,  OP_PRESS, 16'd50,  '0},
            '{ROW_TYPED, REG_TIMEOUT, OP_PRESS,   16'd100, '{EV_NONE, 4'd0, 8'd0, 1'b0, 1'b1}},
            '{ROW_TYPED, REG_TIMEOUT, OP_PRESS,   16'd50,  '{EV_NONE, 4'd0, 8'd0, 1'b0, 1'b1}}
        };

        modes = '{
            '{16'd4,     16'h0000, 16'h000F, 0,  0},
            '{16'd0,     16'h0020, 16'h002F, 74, 0},
            '{16'd6,     16'hFFF0, 16'hFFFF, 0,  74},
            '{16'd3,     16'h1234, 16'h1236, 35, 35},
            '{16'd2,     16'd100,  16'd50,   0,  0},
            '{16'hFFFF,  16'h0000, 16'hFFFF, 0,  0},
            '{16'd8,     16'h8000, 16'h800F, 35, 35}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                wait_idle();
                apb_write(dir_tab[i].rsel, dir_tab[i].kc);
            end else begin
                send_item(dir_tab[i].op, dir_tab[i].kc, dir_tab[i].kind == ROW_TYPED,
                          dir_tab[i].want);
            end
        end

        focus = '0;
        foreach (modes[p]) begin
            wait_idle();
            apb_write(REG_TIMEOUT, modes[p].ticks);
            apb_write(REG_FIRST_CODE, modes[p].lo_code);
            apb_write(REG_LAST_CODE, modes[p].hi_code);
            send_idle_pct  = modes[p].send_pct;
            recv_stall_pct = modes[p].recv_pct;
            focus = cfg_first;
            // receiver holds off while items keep coming, so the queue backs up
            if (p == 0) hold_req++;
            // one key pressed past 255 taps so the counter wraps
            if (p == 5) repeat (260) send_item(OP_PRESS, cfg_first + 16'd7, 1'b0, '0);
            for (int n = 0; n < 6; n++) begin
                if (p == 2 && n == 3) wait_idle();
                if ($urandom_range(99) < 15) focus = cfg_first + 16'($urandom_range(15));
                r = $urandom_range(99);
                if (r < 40)      op = OP_PRESS;
                else if (r < 62) op = OP_RELEASE;
                else if (r < 95) op = OP_TICK;
                else             op = OP_UNUSED;
                r = $urandom_range(99);
                if (r < 55)      kc = focus;
                else if (r < 85) kc = cfg_first + 16'($urandom_range(17));
                else             kc = 16'($urandom);
                send_item(op, kc, 1'b0, '0);
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d key transactions and %0d results under %0d register writes",
                 items_sent, results_seen, cfg_writes);
        $display("timeouts from 0 to 65535, empty and narrow key ranges, counter wrap, backpressure");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
